[hdl/egcd_pkg.sv]
`timescale 1ns / 1ps
package egcd_pkg;
  localparam int unsigned DATA_WIDTH_DEF = 64;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOINV = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;
endpackage

[hdl/egcd_divider.sv]
`timescale 1ns / 1ps
module egcd_divider import egcd_pkg::*; #(
  parameter int unsigned W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  n_r, n_nxt, d_r, q_r, q_nxt;
  logic [W:0]    a_r, a_nxt;
  logic [CW-1:0] cnt_r;
  logic          run_r, nneg_r, qneg_r;
  logic [W:0]    sh, df;
  logic [W-1:0]  qmag, rmag;

  // shift in one dividend bit and try subtracting the divisor magnitude
  always_comb begin
    sh    = {a_r[W-1:0], n_r[W-1]};
    df    = sh - {1'b0, d_r};
    n_nxt = {n_r[W-2:0], 1'b0};
    if (!df[W]) begin
      a_nxt = df;
      q_nxt = {q_r[W-2:0], 1'b1};
    end else begin
      a_nxt = sh;
      q_nxt = {q_r[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done  <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        cnt_r  <= CW'(W);
        n_r    <= dividend[W-1] ? -dividend : dividend;
        d_r    <= divisor[W-1] ? -divisor : divisor;
        a_r    <= '0;
        q_r    <= '0;
        nneg_r <= dividend[W-1];
        qneg_r <= dividend[W-1] ^ divisor[W-1];
      end else if (run_r) begin
        n_r   <= n_nxt;
        a_r   <= a_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  // apply truncating signs
  assign qmag = q_r;
  assign rmag = a_r[W-1:0];
  assign quot = qneg_r ? -qmag : qmag;
  assign rem  = nneg_r ? -rmag : rmag;
endmodule

[hdl/extended_gcd_mod_inverse_unit.sv]
`timescale 1ns / 1ps
// Channel | Ports                                          | Transfer
// input   | in_req_type, in_operand_a, in_operand_b        | start && !busy
// result  | out_gcd_value, out_coef_x, out_coef_y,         | out_valid (1 cycle)
//         | out_inverse_value, out_status                  |
// Each Euclid step runs a test state and a restoring division, then three
// phases for each coefficient multiply on the half-width multiplier. Inverse
// mode adds a final reduction of the x coefficient by the modulus. Busy stays
// high for the whole item. rst_n is synchronous and clears control state. The
// receiver cannot stall; results show for one cycle.
module extended_gcd_mod_inverse_unit import egcd_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  output logic [63:0] out_gcd_value,
  output logic [63:0] out_coef_x,
  output logic [63:0] out_coef_y,
  output logic [62:0] out_inverse_value,
  output logic [1:0]  out_status
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned HW = (W + 1) / 2;
  localparam int unsigned MW = 2 * HW;
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_TEST = 7'b0000010, S_DIV = 7'b0000100,
    S_MS   = 7'b0001000, S_MT = 7'b0010000, S_INV = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;
  state_t st_r;
  logic [W-1:0]     pr_r, cr_r, ps_r, cs_r, pt_r, ct_r, q_r, m_r, acc_r;
  logic [1:0]       ph_r;
  logic             typ_r, dgo, ddone;
  logic [W-1:0]     dvd, dvs, dq, drem, mc, prod;
  logic [W-1:0]     lo;
  logic [MW-1:0]    qx, cx, pp;
  logic [HW-1:0]    ma, mb;
  logic [MW+HW-1:0] ppw;

  assign lo = {1'b1, {(W-1){1'b0}}};
  assign busy = (st_r != S_IDLE);

  egcd_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quot(dq), .rem(drem)
  );

  // shared half-width multiplier; three partial products give the low W bits
  assign mc   = (st_r == S_MS) ? cs_r : ct_r;
  assign qx   = MW'(q_r);
  assign cx   = MW'(mc);
  assign ma   = (ph_r == 2'd2) ? qx[MW-1:HW] : qx[HW-1:0];
  assign mb   = (ph_r == 2'd1) ? cx[MW-1:HW] : cx[HW-1:0];
  assign pp   = ma * mb;
  assign ppw  = {pp, {HW{1'b0}}};
  assign prod = acc_r + ppw[W-1:0];

  always_comb begin
    dvd = pr_r;
    dvs = cr_r;
    if (st_r == S_INV) begin
      dvd = pr_r[W-1] ? -ps_r : ps_r;
      dvs = m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
      dgo       <= 1'b0;
      ph_r      <= '0;
    end else begin
      out_valid <= 1'b0;
      dgo       <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          typ_r <= in_req_type;
          pr_r  <= in_operand_a[W-1:0];
          cr_r  <= in_operand_b[W-1:0];
          m_r   <= in_operand_b[W-1:0];
          ps_r  <= W'(1); cs_r <= '0; pt_r <= '0; ct_r <= W'(1);
          out_inverse_value <= '0;
          out_status <= ST_OK;
          if (in_req_type && (in_operand_b[W-1] || in_operand_b[W-1:0] == '0)) begin
            out_status <= ST_ERR;
            pr_r <= '0; ps_r <= '0; pt_r <= '0;
            st_r <= S_OUT;
          end else st_r <= S_TEST;
        end
        S_TEST: begin
          if (cr_r == '0) begin
            if (typ_r) begin
              if (pr_r inside {W'(1), {W{1'b1}}}) begin
                dgo <= 1'b1;
                st_r <= S_INV;
              end else begin
                out_status <= ST_NOINV;
                st_r <= S_OUT;
              end
            end else st_r <= S_OUT;
          end else if (pr_r == lo && cr_r == '1) begin
            out_status <= ST_ERR;
            pr_r <= '0; ps_r <= '0; pt_r <= '0;
            st_r <= S_OUT;
          end else begin
            dgo  <= 1'b1;
            st_r <= S_DIV;
          end
        end
        S_DIV: if (ddone) begin
          q_r  <= dq;
          pr_r <= cr_r;
          cr_r <= drem;
          st_r <= S_MS;
        end
        // accumulate q*cs over three phases, then advance the s pair
        S_MS: begin
          if (ph_r != 2'd2) begin
            ph_r  <= ph_r + 2'd1;
            acc_r <= (ph_r == 2'd0) ? pp[W-1:0] : prod;
          end else begin
            ps_r <= cs_r;
            cs_r <= ps_r - prod;
            ph_r <= '0;
            st_r <= S_MT;
          end
        end
        // accumulate q*ct over three phases, then advance the t pair
        S_MT: begin
          if (ph_r != 2'd2) begin
            ph_r  <= ph_r + 2'd1;
            acc_r <= (ph_r == 2'd0) ? pp[W-1:0] : prod;
          end else begin
            pt_r <= ct_r;
            ct_r <= pt_r - prod;
            ph_r <= '0;
            st_r <= S_TEST;
          end
        end
        S_INV: if (ddone) begin
          out_inverse_value <= 63'(drem[W-1] ? drem + m_r : drem);
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_gcd_value = 64'($signed(pr_r));
  assign out_coef_x    = 64'($signed(ps_r));
  assign out_coef_y    = 64'($signed(pt_r));
endmodule
